// ===== src/ampp_pkg.sv =====
// Package for the address-list payload parser: status codes, entry layout
// constants and the result beat structure. No dependencies.
`timescale 1ns / 1ps

package ampp_pkg;

   // Result status codes
   localparam logic [2:0] STATUS_ENTRY     = 3'd0;
   localparam logic [2:0] STATUS_EMPTY     = 3'd1;
   localparam logic [2:0] STATUS_OVERFLOW  = 3'd2;
   localparam logic [2:0] STATUS_UNDERFLOW = 3'd3;
   localparam logic [2:0] STATUS_TRUNCATED = 3'd4;

   // Input kinds carried on tuser
   localparam logic OP_START = 1'b0;
   localparam logic OP_BYTE  = 1'b1;

   // Compact-size prefixes
   localparam logic [7:0] PREFIX_U16 = 8'hFD;
   localparam logic [7:0] PREFIX_U32 = 8'hFE;

   // Entry layout and list limit
   localparam int ENTRY_SIZE  = 30;
   localparam int MAX_ENTRIES = 1000;

   // Port widths
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 256;

   // One result beat
   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] timestamp;
      logic [63:0] services;
      logic [63:0] address_high;
      logic [63:0] address_low;
      logic [15:0] port_number;
      logic        port_zero;
      logic [9:0]  entry_number;
      logic        last_entry;
   } rsp_type;

endpackage

// ===== src/addr_message_payload_parser_top.sv =====
// Address-list payload parser, top level: compact-size count decode, count
// checks, 30-byte entry assembly and a two-deep result buffer. Uses ampp_pkg.
`timescale 1ns / 1ps

// Usage:
//  req_* channel: a start beat (tuser = 0) gives the payload length, then
//  byte beats (tuser = 1) deliver the payload one byte each. A start beat in
//  the middle of a message drops that message and begins a new one.
//  rsp_* channel: one beat per decoded entry (tuser = status 0), or one
//  status beat for an empty list, a count overflow, a length underflow or a
//  truncated count. tlast marks the final beat of a message.
//  Throughput: one request beat per cycle while the skid entry is free; each
//  beat is decoded in the cycle it is accepted; its result, if any, enters
//  the output register, or the skid entry behind a held output beat. Bytes
//  past the last entry, and bytes while no message is open, give no result.
//  Reset: the parser goes idle and the result buffer empties.
//  Stall: the result register plus one skid entry absorb a stalled receiver;
//  req_tready drops only while the skid entry is occupied.
module addr_message_payload_parser_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [19:0] payload_length, [27:20] data_byte, [31:28] zero
   input  logic [ampp_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] op
   input  logic                           req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [31:0] timestamp, [95:32] services, [159:96] address_high,
   // [223:160] address_low, [239:224] port_number, [240] port_zero,
   // [250:241] entry_number, [255:251] zero
   output logic [ampp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [2:0] status
   output logic [2:0]                     rsp_tuser,
   output logic                           rsp_tlast
);
   import ampp_pkg::*;

   localparam int HIST_N = ENTRY_SIZE - 1;
   localparam logic [4:0] LAST_BYTE = 5'(ENTRY_SIZE - 1);
   localparam logic [9:0] MAX_CNT   = 10'(MAX_ENTRIES);

   // Parse phases
   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_PREFIX = 3'd1;
   localparam logic [2:0] PH_COUNT  = 3'd2;
   localparam logic [2:0] PH_ENTRY  = 3'd3;
   localparam logic [2:0] PH_TRAIL  = 3'd4;

   // Parser state
   logic [2:0]  phase_ff, phase_in;
   logic [19:0] bytes_left_ff, bytes_left_in;
   logic [3:0]  count_need_ff, count_need_in;
   logic [3:0]  count_idx_ff, count_idx_in;
   logic [9:0]  count_low_ff, count_low_in;
   logic        count_high_ff, count_high_in;
   logic [9:0]  entries_left_ff, entries_left_in;
   logic [9:0]  entry_counter_ff, entry_counter_in;
   logic [4:0]  entry_idx_ff, entry_idx_in;
   logic [7:0]  hist_ff [HIST_N];
   logic [7:0]  hist_in [HIST_N];

   // Result buffer
   rsp_type     out_ff, out_in, skid_ff, skid_in, res;
   logic        out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;
   logic        res_valid;

   logic        req_take;
   logic        out_take;

   assign req_tready = !skid_valid_ff;
   assign req_take   = req_tvalid && req_tready;
   assign out_take   = out_valid_ff && rsp_tready;

   // Decode one request beat
   always_comb begin
      logic [19:0] len;
      logic [7:0]  b;
      logic [19:0] bl_dec;
      logic [3:0]  extra;
      logic [3:0]  idx_inc;
      logic [4:0]  eff_idx;
      logic [9:0]  left_dec;
      logic [14:0] need_bytes;
      logic        do_check;
      logic [15:0] port;

      len        = req_tdata[19:0];
      b          = req_tdata[27:20];
      bl_dec     = bytes_left_ff - 20'd1;
      extra      = 4'd8;
      idx_inc    = count_idx_ff + 4'd1;
      eff_idx    = 5'd0;
      left_dec   = entries_left_ff - 10'd1;
      need_bytes = 15'd0;
      do_check   = 1'b0;
      port       = 16'd0;

      phase_in         = phase_ff;
      bytes_left_in    = bytes_left_ff;
      count_need_in    = count_need_ff;
      count_idx_in     = count_idx_ff;
      count_low_in     = count_low_ff;
      count_high_in    = count_high_ff;
      entries_left_in  = entries_left_ff;
      entry_counter_in = entry_counter_ff;
      entry_idx_in     = entry_idx_ff;
      hist_in          = hist_ff;

      res            = '0;
      res.status     = STATUS_TRUNCATED;
      res.last_entry = 1'b1;
      res_valid      = 1'b0;

      if (req_take) begin
         if (req_tuser == OP_START) begin
            // open a new message
            bytes_left_in    = len;
            count_need_in    = 4'd0;
            count_idx_in     = 4'd0;
            count_low_in     = 10'd0;
            count_high_in    = 1'b0;
            entries_left_in  = 10'd0;
            entry_counter_in = 10'd0;
            entry_idx_in     = 5'd0;
            if (len == 20'd0) begin
               res_valid = 1'b1;
               phase_in  = PH_IDLE;
            end else begin
               phase_in = PH_PREFIX;
            end
         end else if ((phase_ff == PH_PREFIX || phase_ff == PH_COUNT ||
                       phase_ff == PH_ENTRY) && bytes_left_ff != 20'd0) begin
            bytes_left_in = bl_dec;
            case (phase_ff)
               PH_PREFIX: begin
                  count_idx_in  = 4'd0;
                  count_high_in = 1'b0;
                  if (b < PREFIX_U16) begin
                     count_low_in = {2'b00, b};
                     do_check     = 1'b1;
                  end else begin
                     count_low_in = 10'd0;
                     if (b == PREFIX_U16) begin
                        extra = 4'd2;
                     end else if (b == PREFIX_U32) begin
                        extra = 4'd4;
                     end
                     count_need_in = extra;
                     if (bl_dec < {16'd0, extra}) begin
                        res_valid = 1'b1;
                        phase_in  = PH_IDLE;
                     end else begin
                        phase_in = PH_COUNT;
                     end
                  end
               end
               PH_COUNT: begin
                  // fold the next little-endian count byte in
                  case (count_idx_ff[2:0])
                     3'd0:    count_low_in[7:0] = b;
                     3'd1: begin
                        count_low_in[9:8] = b[1:0];
                        count_high_in     = count_high_ff | (|b[7:2]);
                     end
                     default: count_high_in = count_high_ff | (|b);
                  endcase
                  count_idx_in = idx_inc;
                  if (idx_inc >= count_need_ff) begin
                     do_check = 1'b1;
                  end
               end
               default: begin
                  // entry byte: shift history, emit on the final byte
                  eff_idx = (entry_idx_ff > LAST_BYTE) ? 5'd0 : entry_idx_ff;
                  for (int i = 0; i < HIST_N - 1; i++) begin
                     hist_in[i] = hist_ff[i + 1];
                  end
                  hist_in[HIST_N - 1] = b;
                  if (eff_idx == LAST_BYTE) begin
                     entry_idx_in = 5'd0;
                     port         = {hist_ff[HIST_N - 1], b};
                     for (int i = 0; i < 4; i++) begin
                        res.timestamp[i*8 +: 8] = hist_ff[i];
                     end
                     for (int i = 0; i < 8; i++) begin
                        res.services[i*8 +: 8]           = hist_ff[4 + i];
                        res.address_high[(7-i)*8 +: 8] = hist_ff[12 + i];
                        res.address_low[(7-i)*8 +: 8]  = hist_ff[20 + i];
                     end
                     res.status       = STATUS_ENTRY;
                     res.port_number  = port;
                     res.port_zero    = (port == 16'd0);
                     res.entry_number = entry_counter_ff;
                     res.last_entry   = (left_dec == 10'd0);
                     res_valid        = 1'b1;
                     entry_counter_in = entry_counter_ff + 10'd1;
                     entries_left_in  = left_dec;
                     if (left_dec == 10'd0) begin
                        phase_in = PH_TRAIL;
                     end
                  end else begin
                     entry_idx_in = eff_idx + 5'd1;
                  end
               end
            endcase

            // check the decoded count against the limit and the bytes left
            if (do_check) begin
               need_bytes = {count_low_in, 5'b00000} - {4'd0, count_low_in, 1'b0};
               if (count_high_in || count_low_in > MAX_CNT) begin
                  res.status = STATUS_OVERFLOW;
                  res_valid  = 1'b1;
                  phase_in   = PH_IDLE;
               end else if (bl_dec < {5'd0, need_bytes}) begin
                  res.status = STATUS_UNDERFLOW;
                  res_valid  = 1'b1;
                  phase_in   = PH_IDLE;
               end else if (count_low_in == 10'd0) begin
                  res.status = STATUS_EMPTY;
                  res_valid  = 1'b1;
                  phase_in   = PH_IDLE;
               end else begin
                  entries_left_in  = count_low_in;
                  entry_counter_in = 10'd0;
                  entry_idx_in     = 5'd0;
                  phase_in         = PH_ENTRY;
               end
            end
         end
      end
   end

   // Route results through the output register and the skid entry
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || out_take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = res;
            out_valid_in = res_valid;
         end
      end else if (res_valid) begin
         skid_in       = res;
         skid_valid_in = 1'b1;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         bytes_left_ff    <= 20'd0;
         count_need_ff    <= 4'd0;
         count_idx_ff     <= 4'd0;
         count_low_ff     <= 10'd0;
         count_high_ff    <= 1'b0;
         entries_left_ff  <= 10'd0;
         entry_counter_ff <= 10'd0;
         entry_idx_ff     <= 5'd0;
         out_valid_ff     <= 1'b0;
         skid_valid_ff    <= 1'b0;
      end else begin
         phase_ff         <= phase_in;
         bytes_left_ff    <= bytes_left_in;
         count_need_ff    <= count_need_in;
         count_idx_ff     <= count_idx_in;
         count_low_ff     <= count_low_in;
         count_high_ff    <= count_high_in;
         entries_left_ff  <= entries_left_in;
         entry_counter_ff <= entry_counter_in;
         entry_idx_ff     <= entry_idx_in;
         out_valid_ff     <= out_valid_in;
         skid_valid_ff    <= skid_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      hist_ff <= hist_in;
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   // Drive the result channel
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.status;
   assign rsp_tlast  = out_ff.last_entry;
   assign rsp_tdata  = {5'd0, out_ff.entry_number, out_ff.port_zero, out_ff.port_number,
                        out_ff.address_low, out_ff.address_high, out_ff.services,
                        out_ff.timestamp};

   // The skid entry fills only behind a held output beat
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid without output beat");

   // A new result never arrives while the skid entry is full
   assert property (@(posedge clock) disable iff (reset)
      res_valid |-> !skid_valid_ff)
      else $error("result produced with skid entry occupied");

   // Every status beat closes its message
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != STATUS_ENTRY) |-> rsp_tlast)
      else $error("status beat without tlast");

   // Entry phase always has entries outstanding
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_ENTRY) |-> (entries_left_ff != 10'd0))
      else $error("entry phase with no entries left");

endmodule

// ===== test/testbench.sv =====
// Testbench for addr_message_payload_parser_top: directed table plus random
// address-list messages, checked against an in-bench decoder. Uses ampp_pkg.
`timescale 1ns / 1ps

module testbench;
   import ampp_pkg::*;

   localparam int ITEM_TARGET = 1500;
   localparam int CALM_AT     = ITEM_TARGET - 250;
   localparam int FILL_AT     = 560;
   localparam int HOLD_AT     = 600;
   localparam int HOLD_CYCLES = 300;
   localparam int STALL_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 8;

   localparam logic [7:0] PREFIX_U64 = 8'hFF;

   // Decoder phases
   typedef enum logic [2:0] {
      PH_IDLE, PH_PREFIX, PH_COUNT, PH_ENTRY, PH_TRAIL
   } parse_phase_type;

   // How a table row is checked
   typedef enum logic [1:0] {CHECK_MODEL, CHECK_SILENT, CHECK_STATUS} verdict_type;

   typedef struct {
      logic        op;
      logic [19:0] len;
      logic [7:0]  dbyte;
      verdict_type how;
      logic [2:0]  status;
   } table_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = OP_START;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [2:0]            rsp_tuser;
   logic                  rsp_tlast;

   // Decoder state
   parse_phase_type phase = PH_IDLE;
   logic [19:0]  left_bytes = '0;
   logic [7:0]   count_prefix = '0;
   logic [63:0]  count_acc = '0;
   logic [3:0]   count_idx = '0;
   logic [9:0]   entries_due = '0;
   logic [9:0]   entry_seq = '0;
   logic [4:0]   entry_pos = '0;
   logic [7:0]   entry_buf [0:ENTRY_SIZE-1];

   rsp_type       awaited_entries [$];
   table_row_type directed_rows [0:23];
   int            fed_count = 0;
   int            fail_count = 0;
   bit            calm = 1'b0;
   bit            steady = 1'b0;

   addr_message_payload_parser_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic rsp_type status_only(input logic [2:0] st);
      rsp_type r;
      r = '0;
      r.status = st;
      r.last_entry = 1'b1;
      return r;
   endfunction

   function automatic int extra_bytes(input logic [7:0] pfx);
      return (pfx == PREFIX_U16) ? 2 : (pfx == PREFIX_U32) ? 4 : 8;
   endfunction

   // Check a complete count against the limit and the bytes left
   function automatic bit judge_count(output rsp_type r);
      r = '0;
      if (count_acc > MAX_ENTRIES) begin
         r = status_only(STATUS_OVERFLOW);
         phase = PH_IDLE;
         return 1'b1;
      end
      if (64'(left_bytes) < count_acc * ENTRY_SIZE) begin
         r = status_only(STATUS_UNDERFLOW);
         phase = PH_IDLE;
         return 1'b1;
      end
      if (count_acc == 0) begin
         r = status_only(STATUS_EMPTY);
         phase = PH_IDLE;
         return 1'b1;
      end
      entries_due = count_acc[9:0];
      entry_seq = '0;
      entry_pos = '0;
      phase = PH_ENTRY;
      return 1'b0;
   endfunction

   // Advance the decoder by one request beat; return 1 when it yields a result
   function automatic bit decode_addr_beat(input logic op, input logic [19:0] len,
                                           input logic [7:0] b, output rsp_type r);
      logic [15:0] port;
      r = '0;
      if (op == OP_START) begin
         left_bytes = len;
         count_prefix = '0;
         count_acc = '0;
         count_idx = '0;
         entries_due = '0;
         entry_seq = '0;
         entry_pos = '0;
         if (len == 0) begin
            r = status_only(STATUS_TRUNCATED);
            phase = PH_IDLE;
            return 1'b1;
         end
         phase = PH_PREFIX;
         return 1'b0;
      end
      if (phase == PH_IDLE || phase == PH_TRAIL || left_bytes == 0) return 1'b0;
      left_bytes--;
      case (phase)
         PH_PREFIX: begin
            count_prefix = b;
            count_acc = '0;
            count_idx = '0;
            if (b < PREFIX_U16) begin
               count_acc = 64'(b);
               return judge_count(r);
            end
            if (left_bytes < extra_bytes(b)) begin
               r = status_only(STATUS_TRUNCATED);
               phase = PH_IDLE;
               return 1'b1;
            end
            phase = PH_COUNT;
            return 1'b0;
         end
         PH_COUNT: begin
            count_acc |= 64'(b) << (count_idx[2:0] * 8);
            count_idx++;
            if (count_idx >= extra_bytes(count_prefix)) return judge_count(r);
            return 1'b0;
         end
         default: begin
            if (entry_pos >= ENTRY_SIZE) entry_pos = '0;
            entry_buf[entry_pos] = b;
            entry_pos++;
            if (entry_pos < ENTRY_SIZE) return 1'b0;
            entry_pos = '0;
            // Timestamp and services little-endian, address and port big-endian
            for (int i = 0; i < 4; i++) r.timestamp[8*i +: 8] = entry_buf[i];
            for (int i = 0; i < 8; i++) begin
               r.services[8*i +: 8] = entry_buf[4 + i];
               r.address_high[8*(7-i) +: 8] = entry_buf[12 + i];
               r.address_low[8*(7-i) +: 8] = entry_buf[20 + i];
            end
            port = {entry_buf[28], entry_buf[29]};
            r.status = STATUS_ENTRY;
            r.port_number = port;
            r.port_zero = (port == 0);
            r.entry_number = entry_seq;
            entry_seq++;
            entries_due--;
            if (entries_due == 0) begin
               r.last_entry = 1'b1;
               phase = PH_TRAIL;
            end
            return 1'b1;
         end
      endcase
   endfunction

   // Offer one request beat, wait for it to be taken, then log its outcome
   task automatic send_beat(input logic op, input logic [19:0] len, input logic [7:0] dbyte,
                            input verdict_type how, input logic [2:0] st);
      rsp_type r;
      bit      got;
      if (!calm && !steady && $urandom_range(0, 9) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {4'd0, dbyte, len};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      fed_count++;
      got = decode_addr_beat(op, len, dbyte, r);
      case (how)
         CHECK_MODEL: if (got) awaited_entries.insert(awaited_entries.size(), r);
         CHECK_STATUS: awaited_entries.insert(awaited_entries.size(), status_only(st));
         default: ;
      endcase
   endtask

   // Build and send one address-list message, well formed or broken
   task automatic random_message(input bit fill);
      int          kind;
      int          w;
      int          total;
      int          keep;
      logic [63:0] cnt;
      logic [7:0]  body [$];
      kind = fill ? 0 : $urandom_range(0, 99);
      steady = fill || ($urandom_range(0, 2) == 0);
      w = 0;
      if (kind >= 88 && kind < 93) begin
         // Prefix that asks for more count bytes than the length allows
         w = 2 << $urandom_range(0, 2);
         total = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, w);
         body.insert(body.size(), w == 2 ? PREFIX_U16 : w == 4 ? PREFIX_U32 : PREFIX_U64);
         repeat (w) body.insert(body.size(), 8'($urandom));
      end else begin
         if (kind < 70 || kind >= 93)
            cnt = fill ? 64'd10 : ($urandom_range(0, 9) == 0) ? 64'($urandom_range(4, 12))
                                                              : 64'($urandom_range(0, 3));
         else if (kind < 80)
            cnt = $urandom_range(0, 1) ? 64'($urandom_range(MAX_ENTRIES + 1, 65535))
                                       : ({$urandom, $urandom} | 64'h1_0000_0000);
         else
            cnt = 64'($urandom_range(1, MAX_ENTRIES));
         // Pick a count encoding, non-canonical ones included
         if (cnt < 64'(PREFIX_U16) && $urandom_range(0, 3) != 0) w = 0;
         else begin
            w = 8;
            if (cnt < 64'h1_0000 && $urandom_range(0, 2) == 0) w = 2;
            else if (cnt < 64'h1_0000_0000 && $urandom_range(0, 1) == 0) w = 4;
         end
         body.insert(body.size(), w == 0 ? cnt[7:0] : w == 2 ? PREFIX_U16
                                        : w == 4 ? PREFIX_U32 : PREFIX_U64);
         for (int i = 0; i < w; i++) body.insert(body.size(), cnt[8*i +: 8]);
         if (kind >= 70 && kind < 80) begin
            total = $urandom_range(1 + w, 20'hFFFFF);
         end else if (kind >= 80 && kind < 88) begin
            total = 1 + w + $urandom_range(0, int'(cnt) * ENTRY_SIZE - 1);
         end else begin
            total = 1 + w + int'(cnt) * ENTRY_SIZE + $urandom_range(0, 3);
            for (int e = 0; e < int'(cnt); e++) begin
               repeat (ENTRY_SIZE - 2) body.insert(body.size(), 8'($urandom));
               if ($urandom_range(0, 3) == 0) begin
                  body.insert(body.size(), 8'h00);
                  body.insert(body.size(), 8'h00);
               end else begin
                  body.insert(body.size(), 8'($urandom));
                  body.insert(body.size(), 8'($urandom));
               end
            end
            keep = total + $urandom_range(0, 2);
            while (body.size() < keep) body.insert(body.size(), 8'($urandom));
            // Cut the message short so that the next start drops it
            if (kind >= 93) begin
               keep = $urandom_range(1, body.size() - 1);
               while (body.size() > keep) void'(body.pop_back());
            end
         end
      end
      // Stray bytes ahead of the start
      if (!fill && $urandom_range(0, 7) == 0)
         repeat ($urandom_range(1, 3))
            send_beat(OP_BYTE, 20'($urandom), 8'($urandom), CHECK_MODEL, STATUS_ENTRY);
      send_beat(OP_START, total[19:0], 8'($urandom), CHECK_MODEL, STATUS_ENTRY);
      foreach (body[i]) send_beat(OP_BYTE, 20'($urandom), body[i], CHECK_MODEL, STATUS_ENTRY);
   endtask

   function automatic void flag_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
   endfunction

   // Compare each result beat with the oldest expectation
   always @(posedge clock) begin : rsp_check
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status       = rsp_tuser;
         got.timestamp    = rsp_tdata[31:0];
         got.services     = rsp_tdata[95:32];
         got.address_high = rsp_tdata[159:96];
         got.address_low  = rsp_tdata[223:160];
         got.port_number  = rsp_tdata[239:224];
         got.port_zero    = rsp_tdata[240];
         got.entry_number = rsp_tdata[250:241];
         got.last_entry   = rsp_tlast;
         if (awaited_entries.size() == 0) begin
            $error("result beat with nothing expected, status %0d", rsp_tuser);
            fail_count++;
         end else begin
            want = awaited_entries.pop_front();
            if (got.status !== want.status) flag_field("status", want.status, got.status);
            if (got.timestamp !== want.timestamp)
               flag_field("timestamp", want.timestamp, got.timestamp);
            if (got.services !== want.services)
               flag_field("services", want.services, got.services);
            if (got.address_high !== want.address_high)
               flag_field("address_high", want.address_high, got.address_high);
            if (got.address_low !== want.address_low)
               flag_field("address_low", want.address_low, got.address_low);
            if (got.port_number !== want.port_number)
               flag_field("port_number", want.port_number, got.port_number);
            if (got.port_zero !== want.port_zero)
               flag_field("port_zero", want.port_zero, got.port_zero);
            if (got.entry_number !== want.entry_number)
               flag_field("entry_number", want.entry_number, got.entry_number);
            if (got.last_entry !== want.last_entry)
               flag_field("last_entry", want.last_entry, got.last_entry);
         end
      end
   end

   // Receiver: random stalls, one long hold-off to back up the parser
   initial begin
      bit held;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && fed_count >= HOLD_AT) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (!calm && !steady && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // End the run when neither channel moves for too long
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("addr_message_payload_parser_top regression: fail");
      $finish;
   end

   // Stimulus
   initial begin
      bit fill_done;
      fill_done = 1'b0;
      directed_rows = '{
         // byte with no open message: dropped
         '{OP_BYTE,  20'h00000, 8'hFF, CHECK_SILENT, STATUS_ENTRY},
         // zero payload length
         '{OP_START, 20'h00000, 8'h00, CHECK_STATUS, STATUS_TRUNCATED},
         // one-byte count of zero
         '{OP_START, 20'd1,     8'h00, CHECK_SILENT, STATUS_ENTRY},
         '{OP_BYTE,  20'h00000, 8'h00, CHECK_STATUS, STATUS_EMPTY},
         // trailing byte after a status: dropped
         '{OP_BYTE,  20'hFFFFF, 8'h5A, CHECK_SILENT, STATUS_ENTRY},
         // 0xFD prefix with only one byte behind it
         '{OP_START, 20'd2,     8'h00, CHECK_SILENT, STATUS_ENTRY},
         '{OP_BYTE,  20'h00000, 8'hFD, CHECK_STATUS, STATUS_TRUNCATED},
         // 0xFF prefix with seven bytes behind it
         '{OP_START, 20'd8,     8'h00, CHECK_SILENT, STATUS_ENTRY},
         '{OP_BYTE,  20'h00000, 8'hFF, CHECK_STATUS, STATUS_TRUNCATED},
         // non-canonical zero count in two bytes
         '{OP_START, 20'd3,     8'h00, CHECK_SILENT, STATUS_ENTRY},
         '{OP_BYTE,  20'h00000, 8'hFD, CHECK_MODEL,  STATUS_ENTRY},
         '{OP_BYTE,  20'h00000, 8'h00, CHECK_MODEL,  STATUS_ENTRY},
         '{OP_BYTE,  20'h00000, 8'h00, CHECK_STATUS, STATUS_EMPTY},
         // count 1001 in four bytes at the longest length: overflow
         '{OP_START, 20'hFFFFF, 8'h00, CHECK_SILENT, STATUS_ENTRY},
         '{OP_BYTE,  20'h00000, 8'hFE, CHECK_MODEL,  STATUS_ENTRY},
         '{OP_BYTE,  20'h00000, 8'hE9, CHECK_MODEL,  STATUS_ENTRY},
         '{OP_BYTE,  20'h00000, 8'h03, CHECK_MODEL,  STATUS_ENTRY},
         '{OP_BYTE,  20'h00000, 8'h00, CHECK_MODEL,  STATUS_ENTRY},
         '{OP_BYTE,  20'h00000, 8'h00, CHECK_STATUS, STATUS_OVERFLOW},
         // 252 entries opened, then dropped by a new start
         '{OP_START, 20'd7561,  8'h00, CHECK_SILENT, STATUS_ENTRY},
         '{OP_BYTE,  20'h00000, 8'hFC, CHECK_MODEL,  STATUS_ENTRY},
         '{OP_BYTE,  20'h00000, 8'hA7, CHECK_MODEL,  STATUS_ENTRY},
         // one entry promised, no room for it
         '{OP_START, 20'd1,     8'hFF, CHECK_SILENT, STATUS_ENTRY},
         '{OP_BYTE,  20'h00000, 8'h01, CHECK_STATUS, STATUS_UNDERFLOW}
      };
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i])
         send_beat(directed_rows[i].op, directed_rows[i].len, directed_rows[i].dbyte,
                   directed_rows[i].how, directed_rows[i].status);
      while (fed_count < ITEM_TARGET) begin
         if (fed_count >= CALM_AT) calm = 1'b1;
         if (!fill_done && fed_count >= FILL_AT) begin
            fill_done = 1'b1;
            random_message(1'b1);
         end else begin
            random_message(1'b0);
         end
      end
      req_tvalid <= 1'b0;
      // Drain the outstanding results, then let the pipeline settle
      while (awaited_entries.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("addr_message_payload_parser_top regression: pass");
      else
         $display("addr_message_payload_parser_top regression: fail");
      $finish;
   end

endmodule
